### hw/rtl/qsu_pkg.sv
// Shared types, constants and a helper function for the quoted string unescaper.
`default_nettype none
package qsu_pkg;

	localparam int unsigned CharW  = 21;
	localparam int unsigned AccumW = 24;
	localparam int unsigned CountW = 3;
	localparam int unsigned HalfW  = 10;
	localparam int unsigned KindW  = 2;
	localparam int unsigned ErrW   = 3;

	// Result kinds.
	localparam logic [KindW-1:0] KIND_CHAR  = 2'd0;
	localparam logic [KindW-1:0] KIND_CLOSE = 2'd1;
	localparam logic [KindW-1:0] KIND_ERROR = 2'd2;

	// Error codes.
	localparam logic [ErrW-1:0] ERR_NONE     = 3'd0;
	localparam logic [ErrW-1:0] ERR_ESCAPE   = 3'd1;
	localparam logic [ErrW-1:0] ERR_CONTROL  = 3'd2;
	localparam logic [ErrW-1:0] ERR_HEX      = 3'd3;
	localparam logic [ErrW-1:0] ERR_SURR     = 3'd4;
	localparam logic [ErrW-1:0] ERR_END      = 3'd5;

	// Code points that steer the parser.
	localparam logic [CharW-1:0] CH_QUOTE  = 21'h22;
	localparam logic [CharW-1:0] CH_BSLASH = 21'h5C;
	localparam logic [CharW-1:0] CH_SLASH  = 21'h2F;
	localparam logic [CharW-1:0] CH_TAB    = 21'h09;
	localparam logic [CharW-1:0] CH_SPACE  = 21'h20;
	localparam logic [CharW-1:0] CH_LBRACE = 21'h7B;
	localparam logic [CharW-1:0] CH_RBRACE = 21'h7D;
	localparam logic [CharW-1:0] CH_B      = 21'h62;
	localparam logic [CharW-1:0] CH_F      = 21'h66;
	localparam logic [CharW-1:0] CH_N      = 21'h6E;
	localparam logic [CharW-1:0] CH_R      = 21'h72;
	localparam logic [CharW-1:0] CH_T      = 21'h74;
	localparam logic [CharW-1:0] CH_U      = 21'h75;

	localparam logic [AccumW-1:0] MAX_CODE      = 24'h10FFFF;
	localparam logic [12:0]       SURR_TAG      = 13'h1B;
	localparam logic [13:0]       HIGH_SURR_TAG = 14'h36;
	localparam logic [13:0]       LOW_SURR_TAG  = 14'h37;
	localparam logic [CharW-1:0]  SUPP_BASE     = 21'h10000;
	localparam logic [CountW-1:0] UNBRACED_DIGITS = 3'd4;
	localparam logic [CountW-1:0] BRACED_DIGITS   = 3'd6;

	typedef enum logic [6:0] {
		PH_IDLE     = 7'b0000001,
		PH_BODY     = 7'b0000010,
		PH_ESC      = 7'b0000100,
		PH_HEXSTART = 7'b0001000,
		PH_HEX      = 7'b0010000,
		PH_SUR_BS   = 7'b0100000,
		PH_SUR_U    = 7'b1000000
	} phase_t;

	typedef struct packed {
		phase_t              phase;
		logic [AccumW-1:0]   hex_accum;
		logic [CountW-1:0]   digit_count;
		logic                braced_form;
		logic [HalfW-1:0]    high_half;
		logic                in_low_half;
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [KindW-1:0]  kind;
		logic [CharW-1:0]  char_out;
		logic [ErrW-1:0]   error_code;
	} result_t;

	localparam state_t STATE_IDLE = '{
		phase: PH_IDLE, hex_accum: '0, digit_count: '0,
		braced_form: 1'b0, high_half: '0, in_low_half: 1'b0
	};

	// Hex digit decode: bit 4 says the code point is a hex digit, bits 3:0 its value.
	function automatic logic [4:0] hex_digit(input logic [CharW-1:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 21'h30 && c <= 21'h39) begin
			r = {1'b1, 4'(c[3:0])};
		end else if ((c >= 21'h61 && c <= 21'h66) || (c >= 21'h41 && c <= 21'h46)) begin
			r = {1'b1, 4'(c[3:0] + 4'd9)};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/qsu_step.sv
// Next-state and result logic for one code point of the unescaper.
`default_nettype none
module qsu_step (
	input  wire logic [qsu_pkg::CharW-1:0] char_code,
	input  wire logic                      end_of_input,
	input  wire qsu_pkg::state_t           cur,
	output qsu_pkg::state_t                nxt,
	output qsu_pkg::result_t               res
);

	logic [4:0]                    hd;
	logic [qsu_pkg::AccumW-1:0]    acc_in;
	logic [qsu_pkg::CountW-1:0]    cnt_in;
	logic                          braced_in;
	logic [qsu_pkg::AccumW-1:0]    acc_new;
	logic [qsu_pkg::CountW-1:0]    cnt_new;
	logic                          do_hex;
	logic                          do_finish;
	logic                          do_hexfail;
	logic [qsu_pkg::AccumW-1:0]    code;

	assign hd = qsu_pkg::hex_digit(char_code);

	always_comb begin
		nxt        = cur;
		res        = '0;
		acc_in     = cur.hex_accum;
		cnt_in     = cur.digit_count;
		braced_in  = cur.braced_form;
		do_hex     = 1'b0;
		do_finish  = 1'b0;
		do_hexfail = 1'b0;
		code       = '0;

		if (cur.phase == qsu_pkg::PH_IDLE) begin
			if (!end_of_input && char_code == qsu_pkg::CH_QUOTE) begin
				nxt.phase = qsu_pkg::PH_BODY;
			end
		end else if (end_of_input) begin
			nxt = qsu_pkg::STATE_IDLE;
			res = '{valid: 1'b1, kind: qsu_pkg::KIND_ERROR, char_out: '0,
				error_code: qsu_pkg::ERR_END};
		end else begin
			case (cur.phase)
				qsu_pkg::PH_BODY: begin
					if (char_code == qsu_pkg::CH_BSLASH) begin
						nxt.phase = qsu_pkg::PH_ESC;
					end else if (char_code < qsu_pkg::CH_SPACE && char_code != qsu_pkg::CH_TAB) begin
						nxt = qsu_pkg::STATE_IDLE;
						res = '{valid: 1'b1, kind: qsu_pkg::KIND_ERROR, char_out: '0,
							error_code: qsu_pkg::ERR_CONTROL};
					end else if (char_code == qsu_pkg::CH_QUOTE) begin
						nxt = qsu_pkg::STATE_IDLE;
						res = '{valid: 1'b1, kind: qsu_pkg::KIND_CLOSE, char_out: '0,
							error_code: qsu_pkg::ERR_NONE};
					end else begin
						res = '{valid: 1'b1, kind: qsu_pkg::KIND_CHAR, char_out: char_code,
							error_code: qsu_pkg::ERR_NONE};
					end
				end
				qsu_pkg::PH_ESC: begin
					nxt.phase = qsu_pkg::PH_BODY;
					res = '{valid: 1'b1, kind: qsu_pkg::KIND_CHAR, char_out: char_code,
						error_code: qsu_pkg::ERR_NONE};
					case (char_code)
						qsu_pkg::CH_QUOTE, qsu_pkg::CH_BSLASH, qsu_pkg::CH_SLASH: begin
							res.char_out = char_code;
						end
						qsu_pkg::CH_B: res.char_out = 21'h08;
						qsu_pkg::CH_F: res.char_out = 21'h0C;
						qsu_pkg::CH_N: res.char_out = 21'h0A;
						qsu_pkg::CH_R: res.char_out = 21'h0D;
						qsu_pkg::CH_T: res.char_out = 21'h09;
						qsu_pkg::CH_U: begin
							res             = '0;
							nxt.phase       = qsu_pkg::PH_HEXSTART;
							nxt.hex_accum   = '0;
							nxt.digit_count = '0;
							nxt.braced_form = 1'b0;
							nxt.in_low_half = 1'b0;
						end
						default: begin
							nxt = qsu_pkg::STATE_IDLE;
							res = '{valid: 1'b1, kind: qsu_pkg::KIND_ERROR, char_out: '0,
								error_code: qsu_pkg::ERR_ESCAPE};
						end
					endcase
				end
				qsu_pkg::PH_HEXSTART: begin
					nxt.hex_accum   = '0;
					nxt.digit_count = '0;
					nxt.phase       = qsu_pkg::PH_HEX;
					if (char_code == qsu_pkg::CH_LBRACE) begin
						nxt.braced_form = 1'b1;
					end else begin
						nxt.braced_form = 1'b0;
						acc_in    = '0;
						cnt_in    = '0;
						braced_in = 1'b0;
						do_hex    = 1'b1;
					end
				end
				qsu_pkg::PH_HEX: begin
					do_hex = 1'b1;
				end
				qsu_pkg::PH_SUR_BS: begin
					if (char_code != qsu_pkg::CH_BSLASH) begin
						nxt = qsu_pkg::STATE_IDLE;
						res = '{valid: 1'b1, kind: qsu_pkg::KIND_ERROR, char_out: '0,
							error_code: qsu_pkg::ERR_SURR};
					end else begin
						nxt.phase = qsu_pkg::PH_SUR_U;
					end
				end
				qsu_pkg::PH_SUR_U: begin
					if (char_code != qsu_pkg::CH_U) begin
						nxt = qsu_pkg::STATE_IDLE;
						res = '{valid: 1'b1, kind: qsu_pkg::KIND_ERROR, char_out: '0,
							error_code: qsu_pkg::ERR_SURR};
					end else begin
						nxt.phase       = qsu_pkg::PH_HEXSTART;
						nxt.in_low_half = 1'b1;
					end
				end
				default: begin
					nxt = qsu_pkg::STATE_IDLE;
				end
			endcase
		end

		// Accumulator and count with the incoming digit shifted in.
		acc_new = {acc_in[qsu_pkg::AccumW-5:0], hd[3:0]};
		cnt_new = cnt_in + 3'd1;

		// One hex digit, or the closing brace of the braced form.
		if (do_hex) begin
			if (braced_in) begin
				if (char_code == qsu_pkg::CH_RBRACE && cnt_in != '0) begin
					do_finish = 1'b1;
					code      = acc_in;
				end else if (!hd[4] || cnt_in >= qsu_pkg::BRACED_DIGITS) begin
					do_hexfail = 1'b1;
				end else begin
					nxt.hex_accum   = acc_new;
					nxt.digit_count = cnt_new;
					if (cnt_new == qsu_pkg::BRACED_DIGITS && acc_new > qsu_pkg::MAX_CODE) begin
						do_hexfail = 1'b1;
					end
				end
			end else begin
				if (!hd[4]) begin
					do_hexfail = 1'b1;
				end else begin
					nxt.hex_accum   = acc_new;
					nxt.digit_count = cnt_new;
					if (cnt_new >= qsu_pkg::UNBRACED_DIGITS) begin
						do_finish = 1'b1;
						code      = acc_new;
					end
				end
			end
		end

		if (do_hexfail) begin
			nxt = qsu_pkg::STATE_IDLE;
			res = '{valid: 1'b1, kind: qsu_pkg::KIND_ERROR, char_out: '0,
				error_code: cur.in_low_half ? qsu_pkg::ERR_SURR : qsu_pkg::ERR_HEX};
		end else if (do_finish) begin
			nxt.hex_accum   = '0;
			nxt.digit_count = '0;
			nxt.braced_form = 1'b0;
			if (cur.in_low_half) begin
				if (code[23:10] == qsu_pkg::LOW_SURR_TAG) begin
					nxt.in_low_half = 1'b0;
					nxt.high_half   = '0;
					nxt.phase       = qsu_pkg::PH_BODY;
					res = '{valid: 1'b1, kind: qsu_pkg::KIND_CHAR,
						char_out: {1'b0, cur.high_half, code[9:0]} + qsu_pkg::SUPP_BASE,
						error_code: qsu_pkg::ERR_NONE};
				end else begin
					nxt = qsu_pkg::STATE_IDLE;
					res = '{valid: 1'b1, kind: qsu_pkg::KIND_ERROR, char_out: '0,
						error_code: qsu_pkg::ERR_SURR};
				end
			end else if (code[23:11] == qsu_pkg::SURR_TAG) begin
				if (code[23:10] == qsu_pkg::HIGH_SURR_TAG) begin
					nxt.high_half = code[9:0];
					nxt.phase     = qsu_pkg::PH_SUR_BS;
				end else begin
					nxt = qsu_pkg::STATE_IDLE;
					res = '{valid: 1'b1, kind: qsu_pkg::KIND_ERROR, char_out: '0,
						error_code: qsu_pkg::ERR_SURR};
				end
			end else begin
				nxt.phase = qsu_pkg::PH_BODY;
				res = '{valid: 1'b1, kind: qsu_pkg::KIND_CHAR, char_out: code[20:0],
					error_code: qsu_pkg::ERR_NONE};
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/quoted_string_unescape.sv
// Top level of the quoted string unescaper: input register, parser state and result register.
// A word waits in the input register, passes the parser step, and its result, if any, is held in the result register.
// Throughput: one input word per cycle while the receiver takes results; a result that
// waits stalls the input as soon as the input register is full as well.
// The rate is set by the combinational parser step between the input and result registers.
// Reset (arst_n low, asynchronous) empties both registers and returns the parser to idle.
`default_nettype none
module quoted_string_unescape (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [qsu_pkg::CharW-1:0]     char_code,
	input  wire logic                          end_of_input,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [qsu_pkg::KindW-1:0]          kind,
	output logic [qsu_pkg::CharW-1:0]          char_out,
	output logic [qsu_pkg::ErrW-1:0]           error_code
);

	// Input register: one word waiting for the parser step.
	logic                       valid_s1;
	logic [qsu_pkg::CharW-1:0]  char_s1;
	logic                       eoi_s1;

	// Parser state, updated only when the word in the input register is consumed.
	qsu_pkg::state_t  state_q;
	qsu_pkg::state_t  state_nxt;
	qsu_pkg::result_t step_res;

	// Result register.
	logic                       valid_s2;
	logic [qsu_pkg::KindW-1:0]  kind_s2;
	logic [qsu_pkg::CharW-1:0]  char_s2;
	logic [qsu_pkg::ErrW-1:0]   err_s2;

	logic advance;

	// The input register moves on whenever the result register has room: either it is
	// empty or its word leaves this cycle. Words that produce no result also need this
	// slot so the step stays in order with any result still waiting.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	qsu_step u_step (
		.char_code    (char_s1),
		.end_of_input (eoi_s1),
		.cur          (state_q),
		.nxt          (state_nxt),
		.res          (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
			eoi_s1  <= end_of_input;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qsu_pkg::STATE_IDLE;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= step_res.valid;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res.valid) begin
			kind_s2 <= step_res.kind;
			char_s2 <= step_res.char_out;
			err_s2  <= step_res.error_code;
		end
	end

	assign out_valid  = valid_s2;
	assign kind       = kind_s2;
	assign char_out   = char_s2;
	assign error_code = err_s2;

endmodule
`default_nettype wire

### hw/rtl/qsu_checker.sv
// Port-level checker for the quoted string unescaper and its bind statement.
`default_nettype none
module qsu_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic [qsu_pkg::KindW-1:0]  kind,
	input wire logic [qsu_pkg::CharW-1:0]  char_out,
	input wire logic [qsu_pkg::ErrW-1:0]   error_code
);

	// Only the three defined kinds ever leave the block.
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == qsu_pkg::KIND_CHAR || kind == qsu_pkg::KIND_CLOSE ||
			kind == qsu_pkg::KIND_ERROR))
		else $error("illegal result kind");

	// An error carries a defined nonzero code; other words carry none.
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((kind == qsu_pkg::KIND_ERROR) ?
			(error_code != qsu_pkg::ERR_NONE && error_code <= qsu_pkg::ERR_END) :
			(error_code == qsu_pkg::ERR_NONE)))
		else $error("error code does not match kind");

	// Closing quotes and errors carry a zero character field.
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != qsu_pkg::KIND_CHAR) |-> (char_out == '0))
		else $error("character field not zero");

	// A stalled result stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(kind) && $stable(char_out) &&
			$stable(error_code)))
		else $error("result changed while stalled");

endmodule

bind quoted_string_unescape qsu_checker u_qsu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.kind       (kind),
	.char_out   (char_out),
	.error_code (error_code)
);
`default_nettype wire
